FILE: sv/vpp_pkg.sv
// Shared types and constants of the vertex perspective projector.
`default_nettype none
package vpp_pkg;

    // register indexes of the configuration port
    localparam logic [2:0] CFG_ROTATE_PART   = 3'd0;
    localparam logic [2:0] CFG_OFFSET_X      = 3'd1;
    localparam logic [2:0] CFG_OFFSET_Y      = 3'd2;
    localparam logic [2:0] CFG_VIEW_COS      = 3'd3;
    localparam logic [2:0] CFG_VIEW_SIN      = 3'd4;
    localparam logic [2:0] CFG_HEIGHT_OFFSET = 3'd5;
    localparam logic [2:0] CFG_PART_COS      = 3'd6;
    localparam logic [2:0] CFG_PART_SIN      = 3'd7;

    // arithmetic widths
    localparam int NUM_W = 48;   // numerator magnitude
    localparam int DEN_W = 36;   // clamped depth, Q12
    localparam int QUO_W = 18;   // quotient bits developed before saturation
    localparam int DIV_LAT = QUO_W + 1;

    localparam logic signed [DEN_W-1:0] DEPTH_MIN = 36'sd40960;  // 10.0 in Q12
    localparam logic signed [NUM_W-1:0] CENTER_X  = 48'sd500;
    localparam logic signed [NUM_W-1:0] CENTER_Y  = 48'sd260;
    localparam logic signed [NUM_W-1:0] FOCAL     = 48'sd450;

    typedef struct packed {
        logic clamped;
        logic last;
    } t_side;

endpackage
`default_nettype wire

FILE: sv/vpp_div.sv
// Pipelined restoring divider, one quotient bit per stage, signed saturating result.
`default_nettype none
module vpp_div (
    input  wire logic                      i_clk,
    input  wire logic                      i_en,
    input  wire logic [vpp_pkg::NUM_W-1:0] i_num,
    input  wire logic [vpp_pkg::DEN_W-1:0] i_den,
    input  wire logic                      i_neg,
    output logic signed [15:0]             o_quo
);
    localparam int NW = vpp_pkg::NUM_W;
    localparam int DW = vpp_pkg::DEN_W;
    localparam int QW = vpp_pkg::QUO_W;
    localparam int CW = NW + QW;

    logic [NW-1:0] r_rem [0:QW-1];
    logic [DW-1:0] r_den [0:QW-1];
    logic [QW-1:0] r_quo [0:QW-1];
    logic          r_neg [0:QW-1];
    logic signed [15:0] r_out;

    for (genvar k = 0; k < QW; k++) begin : g_step
        localparam int B = QW - 1 - k;
        logic [NW-1:0] w_rem;
        logic [DW-1:0] w_den;
        logic [QW-1:0] w_quo;
        logic          w_neg;
        logic [CW-1:0] w_dsh;
        logic          w_ge;
        if (k == 0) begin : g_first
            assign w_rem = i_num;
            assign w_den = i_den;
            assign w_quo = '0;
            assign w_neg = i_neg;
        end else begin : g_rest
            assign w_rem = r_rem[k-1];
            assign w_den = r_den[k-1];
            assign w_quo = r_quo[k-1];
            assign w_neg = r_neg[k-1];
        end
        assign w_dsh = CW'(w_den) << B;
        assign w_ge  = CW'(w_rem) >= w_dsh;
        always_ff @(posedge i_clk) begin
            if (i_en) begin
                r_rem[k] <= w_ge ? w_rem - NW'(w_dsh) : w_rem;
                r_den[k] <= w_den;
                r_quo[k] <= {w_quo[QW-2:0], w_ge};
                r_neg[k] <= w_neg;
            end
        end
    end

    // sign and saturate to 16 bits
    always_ff @(posedge i_clk) begin
        if (i_en) begin
            if (r_neg[QW-1]) begin
                if (r_quo[QW-1] > QW'(32768)) begin
                    r_out <= -16'sd32768;
                end else begin
                    r_out <= 16'(-r_quo[QW-1]);
                end
            end else begin
                if (r_quo[QW-1] > QW'(32767)) begin
                    r_out <= 16'sd32767;
                end else begin
                    r_out <= 16'(r_quo[QW-1]);
                end
            end
        end
    end

    assign o_quo = r_out;
endmodule
`default_nettype wire

FILE: sv/vertex_perspective_projector.sv
// Top level of the vertex perspective projector.
`default_nettype none
// One model vertex in, one screen position out; one beat per cycle if not held.
// It has six arithmetic stages (part rotation products, offset, view rotation
// products, depth clamp, numerators, magnitude) then a bit-per-stage divider of
// 18 stages plus a saturation stage, one per screen axis. The pipeline advances
// together; it holds only while a finished result waits at the output and the
// sink is not ready. Positions are Q20.12, cos/sin Q2.14; screen_x = 500 +
// lat*450/depth, screen_y = 260 - h*450/depth, truncated toward zero and
// saturated to 16 bits. Depth below 10.0 is raised to 10.0 and flagged in
// tuser. The user writes configuration only while idle; nothing enforces it.
module vertex_perspective_projector (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        i_cfg_we,
    input  wire logic [2:0]  i_cfg_idx,
    input  wire logic [31:0] i_cfg_wdata,
    input  wire logic        s_tvalid,
    output logic             s_tready,
    input  wire logic [39:0] s_tdata,   // vertex_x[10:0], vertex_y[21:11], vertex_z[32:22], 0
    input  wire logic        s_tlast,   // last_vertex
    output logic             m_tvalid,
    input  wire logic        m_tready,
    output logic [31:0]      m_tdata,   // screen_x[15:0], screen_y[31:16]
    output logic             m_tuser,   // depth_clamped
    output logic             m_tlast    // last_out
);
    localparam int NW = vpp_pkg::NUM_W;
    localparam int DW = vpp_pkg::DEN_W;
    localparam int DL = vpp_pkg::DIV_LAT;

    // configuration registers
    logic               r_rotate;
    logic signed [31:0] r_off_x, r_off_y, r_height;
    logic signed [15:0] r_view_cos, r_view_sin, r_part_cos, r_part_sin;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_rotate   <= 1'b0;
            r_off_x    <= '0;
            r_off_y    <= '0;
            r_view_cos <= 16'sd16384;
            r_view_sin <= '0;
            r_height   <= '0;
            r_part_cos <= 16'sd16384;
            r_part_sin <= '0;
        end else if (i_cfg_we) begin
            unique case (i_cfg_idx)
                vpp_pkg::CFG_ROTATE_PART:   r_rotate   <= i_cfg_wdata[0];
                vpp_pkg::CFG_OFFSET_X:      r_off_x    <= i_cfg_wdata;
                vpp_pkg::CFG_OFFSET_Y:      r_off_y    <= i_cfg_wdata;
                vpp_pkg::CFG_VIEW_COS:      r_view_cos <= i_cfg_wdata[15:0];
                vpp_pkg::CFG_VIEW_SIN:      r_view_sin <= i_cfg_wdata[15:0];
                vpp_pkg::CFG_HEIGHT_OFFSET: r_height   <= i_cfg_wdata;
                vpp_pkg::CFG_PART_COS:      r_part_cos <= i_cfg_wdata[15:0];
                vpp_pkg::CFG_PART_SIN:      r_part_sin <= i_cfg_wdata[15:0];
                default: ;
            endcase
        end
    end

    // global advance: move unless a result is stuck at the output
    logic w_en;
    assign w_en     = !m_tvalid || m_tready;
    assign s_tready = w_en;

    logic w_acc;
    assign w_acc = s_tvalid && s_tready;

    logic signed [10:0] w_vx, w_vy, w_vz;
    assign w_vx = s_tdata[10:0];
    assign w_vy = s_tdata[21:11];
    assign w_vz = s_tdata[32:22];

    // stage valids, reset cleared
    logic r1_v, r2_v, r3_v, r4_v, r5_v, r6_v;
    logic [DL-1:0] r_dv;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            {r1_v, r2_v, r3_v, r4_v, r5_v, r6_v} <= '0;
            r_dv <= '0;
        end else if (w_en) begin
            r1_v <= w_acc;
            r2_v <= r1_v;
            r3_v <= r2_v;
            r4_v <= r3_v;
            r5_v <= r4_v;
            r6_v <= r5_v;
            r_dv <= {r_dv[DL-2:0], r6_v};
        end
    end

    // S1: part rotation products, height
    logic signed [10:0] r1_vx, r1_vy;
    logic signed [26:0] r1_pxc, r1_pys, r1_pxs, r1_pyc;
    logic signed [32:0] r1_ht;
    logic               r1_last;
    // S2: offset removed
    logic signed [32:0] r2_rx, r2_ry, r2_ht;
    logic               r2_last;
    // S3: view rotation products
    logic signed [48:0] r3_a, r3_b, r3_c, r3_d;
    logic signed [32:0] r3_ht;
    logic               r3_last;
    // S4: lateral and clamped depth
    logic signed [35:0] r4_lat;
    logic signed [DW-1:0] r4_dep;
    logic signed [32:0] r4_ht;
    logic               r4_clamp, r4_last;
    // S5: numerators
    logic signed [NW-1:0] r5_nx, r5_ny;
    logic [DW-1:0]        r5_dep;
    logic                 r5_clamp, r5_last;
    // S6: magnitudes
    logic [NW-1:0] r6_mx, r6_my;
    logic          r6_nx, r6_ny;
    logic [DW-1:0] r6_dep;
    vpp_pkg::t_side r6_side;

    logic signed [27:0] w_sx, w_sy;
    logic signed [32:0] w_rx0, w_ry0;
    logic signed [49:0] w_lat, w_dep;
    logic signed [35:0] w_lat_q, w_dep_q;

    always_comb begin
        w_sx = 28'(r1_pxc) - 28'(r1_pys);
        w_sy = 28'(r1_pxs) + 28'(r1_pyc);
        if (r_rotate) begin
            w_rx0 = 33'(w_sx >>> 2);
            w_ry0 = 33'(w_sy >>> 2);
        end else begin
            w_rx0 = 33'(r1_vx) <<< 12;
            w_ry0 = 33'(r1_vy) <<< 12;
        end
        w_lat   = 50'(r3_a) + 50'(r3_b);
        w_dep   = 50'(r3_c) - 50'(r3_d);
        w_lat_q = 36'(w_lat >>> 14);
        w_dep_q = 36'(w_dep >>> 14);
    end

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r1_vx   <= w_vx;
            r1_vy   <= w_vy;
            r1_pxc  <= 27'(w_vx) * 27'(r_part_cos);
            r1_pys  <= 27'(w_vy) * 27'(r_part_sin);
            r1_pxs  <= 27'(w_vx) * 27'(r_part_sin);
            r1_pyc  <= 27'(w_vy) * 27'(r_part_cos);
            r1_ht   <= (33'(w_vz) <<< 12) + 33'(r_height);
            r1_last <= s_tlast;

            r2_rx   <= w_rx0 - 33'(r_off_x);
            r2_ry   <= w_ry0 - 33'(r_off_y);
            r2_ht   <= r1_ht;
            r2_last <= r1_last;

            r3_a    <= 49'(r2_rx) * 49'(r_view_cos);
            r3_b    <= 49'(r2_ry) * 49'(r_view_sin);
            r3_c    <= 49'(r2_ry) * 49'(r_view_cos);
            r3_d    <= 49'(r2_rx) * 49'(r_view_sin);
            r3_ht   <= r2_ht;
            r3_last <= r2_last;

            r4_lat  <= w_lat_q;
            if (w_dep_q < vpp_pkg::DEPTH_MIN) begin
                r4_dep   <= vpp_pkg::DEPTH_MIN;
                r4_clamp <= 1'b1;
            end else begin
                r4_dep   <= w_dep_q;
                r4_clamp <= 1'b0;
            end
            r4_ht   <= r3_ht;
            r4_last <= r3_last;

            r5_nx    <= NW'(r4_dep) * vpp_pkg::CENTER_X + NW'(r4_lat) * vpp_pkg::FOCAL;
            r5_ny    <= NW'(r4_dep) * vpp_pkg::CENTER_Y - NW'(r4_ht) * vpp_pkg::FOCAL;
            r5_dep   <= r4_dep;
            r5_clamp <= r4_clamp;
            r5_last  <= r4_last;

            r6_nx   <= r5_nx[NW-1];
            r6_ny   <= r5_ny[NW-1];
            r6_mx   <= r5_nx[NW-1] ? NW'(-r5_nx) : NW'(r5_nx);
            r6_my   <= r5_ny[NW-1] ? NW'(-r5_ny) : NW'(r5_ny);
            r6_dep  <= r5_dep;
            r6_side <= '{clamped: r5_clamp, last: r5_last};
        end
    end

    // side fields ride alongside the dividers
    vpp_pkg::t_side r_side [0:DL-1];
    for (genvar k = 0; k < DL; k++) begin : g_side
        always_ff @(posedge i_clk) begin
            if (w_en) begin
                r_side[k] <= (k == 0) ? r6_side : r_side[k == 0 ? 0 : k-1];
            end
        end
    end

    logic signed [15:0] w_qx, w_qy;

    vpp_div u_div_x (
        .i_clk (i_clk),
        .i_en  (w_en),
        .i_num (r6_mx),
        .i_den (r6_dep),
        .i_neg (r6_nx),
        .o_quo (w_qx)
    );

    vpp_div u_div_y (
        .i_clk (i_clk),
        .i_en  (w_en),
        .i_num (r6_my),
        .i_den (r6_dep),
        .i_neg (r6_ny),
        .o_quo (w_qy)
    );

    assign m_tvalid = r_dv[DL-1];
    assign m_tdata  = {w_qy, w_qx};
    assign m_tuser  = r_side[DL-1].clamped;
    assign m_tlast  = r_side[DL-1].last;

    // depth never below the minimum once clamped
    a_dep_min: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r4_v |-> (r4_dep >= vpp_pkg::DEPTH_MIN))
        else $error("clamped depth below minimum");

    // clamp flag only with the minimum depth
    a_clamp_val: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r4_v && r4_clamp) |-> (r4_dep == vpp_pkg::DEPTH_MIN))
        else $error("clamp flag with other depth");

    // a held result freezes the whole pipeline
    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (m_tvalid && !m_tready) |=> (m_tvalid && $stable(r_dv) && $stable(r6_mx)))
        else $error("pipeline moved while output stalled");

endmodule
`default_nettype wire

FILE: tb/vertex_perspective_projector_tb.sv
// Self-checking testbench of the vertex perspective projector.
`default_nettype none
module vertex_perspective_projector_tb;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int HOLD_CYCLES  = 300;
    localparam int DRAIN_CYCLES = 40;   // pipeline is 25 deep
    localparam int WATCHDOG     = 5000;

    typedef struct packed {
        logic signed [15:0] sx;
        logic signed [15:0] sy;
        logic               clamped;
        logic               lst;
    } t_screen;

    typedef struct {
        int vx, vy, vz;
        bit lst;
        bit typed;     // expected screen position given in the row
        int sx, sy;
        bit clamped;
    } t_vrow;

    logic        i_clk, i_rst_n;
    logic        i_cfg_we;
    logic [2:0]  i_cfg_idx;
    logic [31:0] i_cfg_wdata;
    logic        s_tvalid, s_tready, s_tlast;
    logic [39:0] s_tdata;
    logic        m_tvalid, m_tready, m_tuser, m_tlast;
    logic [31:0] m_tdata;

    vertex_perspective_projector i_dut (.*);

    // local copy of the register file
    bit     rot_on;
    longint off_x, off_y, vw_cos, vw_sin, hgt, pt_cos, pt_sin;

    t_screen  screen_q[$];
    bit       typed_pending;
    t_screen  typed_res;
    int       beats_in, beats_out, mism, idle_cycles, clamped_seen;
    int       gap_pct, stall_pct;
    bit       hold, hold_req;

    initial begin
        i_clk = 1'b0;
        forever #10 i_clk = ~i_clk;
    end

    function automatic t_screen project(logic signed [10:0] vx, logic signed [10:0] vy,
                                        logic signed [10:0] vz, logic lst);
        longint x, y, rx, ry, lat, dep, ht, qx, qy;
        t_screen r;
        x = vx;
        y = vy;
        if (rot_on) begin
            rx = (x * pt_cos - y * pt_sin) >>> 2;
            ry = (x * pt_sin + y * pt_cos) >>> 2;
        end else begin
            rx = x * 4096;
            ry = y * 4096;
        end
        rx -= off_x;
        ry -= off_y;
        lat = (rx * vw_cos + ry * vw_sin) >>> 14;
        dep = (ry * vw_cos - rx * vw_sin) >>> 14;
        r.clamped = (dep < 40960);
        if (r.clamped) dep = 40960;
        ht = longint'(vz) * 4096 + hgt;
        qx = (500 * dep + 450 * lat) / dep;   // truncates toward zero
        qy = (260 * dep - 450 * ht) / dep;
        r.sx = (qx > 32767) ? 16'sh7fff : (qx < -32768) ? 16'sh8000 : qx[15:0];
        r.sy = (qy > 32767) ? 16'sh7fff : (qy < -32768) ? 16'sh8000 : qy[15:0];
        r.lst = lst;
        return r;
    endfunction

    // output check first, then record the input beat of this edge
    always @(posedge i_clk) begin
        t_screen e, got;
        if (i_rst_n && m_tvalid && m_tready) begin
            beats_out++;
            got = {m_tdata[15:0], m_tdata[31:16], m_tuser, m_tlast};
            if (got.clamped) clamped_seen++;
            if (screen_q.size() == 0) begin
                mism++;
                if (mism <= 10) $display("unexpected beat: %p", got);
            end else begin
                e = screen_q.pop_front();
                if (e != got) begin
                    mism++;
                    if (mism <= 10)
                        $display({"mismatch beat %0d: exp x=%0d y=%0d cl=%b l=%b, ",
                                  "got x=%0d y=%0d cl=%b l=%b"},
                                 beats_out, e.sx, e.sy, e.clamped, e.lst,
                                 got.sx, got.sy, got.clamped, got.lst);
                end
            end
        end
        if (i_rst_n && s_tvalid && s_tready) begin
            beats_in++;
            if (typed_pending) begin
                screen_q.push_back(typed_res);
                typed_pending = 0;
            end else
                screen_q.push_back(project(s_tdata[10:0], s_tdata[21:11], s_tdata[32:22],
                                           s_tlast));
        end
        if (!i_rst_n || (s_tvalid && s_tready) || (m_tvalid && m_tready))
            idle_cycles = 0;
        else if (++idle_cycles >= WATCHDOG) begin
            $display("watchdog: no beat for %0d cycles", WATCHDOG);
            $display("Mismatches found");
            $finish;
        end
    end

    // sink readiness; a hold-off request holds it low for a long stretch
    always @(negedge i_clk) begin
        if (hold_req && !hold) begin
            hold = 1;
            m_tready = 1'b0;
            repeat (HOLD_CYCLES) @(negedge i_clk);
            hold = 0;
            hold_req = 0;
        end
        m_tready = ($urandom_range(99) >= stall_pct);
    end

    task automatic write_reg(logic [2:0] idx, logic [31:0] val);
        @(negedge i_clk);
        i_cfg_we = 1'b1;
        i_cfg_idx = idx;
        i_cfg_wdata = val;
        case (idx)
            vpp_pkg::CFG_ROTATE_PART:   rot_on = val[0];
            vpp_pkg::CFG_OFFSET_X:      off_x  = longint'(signed'(val));
            vpp_pkg::CFG_OFFSET_Y:      off_y  = longint'(signed'(val));
            vpp_pkg::CFG_VIEW_COS:      vw_cos = longint'(signed'(val[15:0]));
            vpp_pkg::CFG_VIEW_SIN:      vw_sin = longint'(signed'(val[15:0]));
            vpp_pkg::CFG_HEIGHT_OFFSET: hgt    = longint'(signed'(val));
            vpp_pkg::CFG_PART_COS:      pt_cos = longint'(signed'(val[15:0]));
            vpp_pkg::CFG_PART_SIN:      pt_sin = longint'(signed'(val[15:0]));
            default: ;
        endcase
        @(negedge i_clk);
        i_cfg_we = 1'b0;
    endtask

    // sender pause: wait until every expected beat is back and the pipe is empty
    task automatic drain();
        while (screen_q.size() != 0) @(negedge i_clk);
        repeat (DRAIN_CYCLES) @(negedge i_clk);
    endtask

    task automatic send_vertex(logic [10:0] vx, logic [10:0] vy, logic [10:0] vz, logic lst);
        int target;
        while ($urandom_range(99) < gap_pct) begin
            s_tvalid = 1'b0;
            @(negedge i_clk);
        end
        target = beats_in + 1;
        s_tvalid = 1'b1;
        s_tdata = {7'd0, vz, vy, vx};
        s_tlast = lst;
        do @(negedge i_clk); while (beats_in < target);
        s_tvalid = 1'b0;
    endtask

    function automatic logic [31:0] rand_trig();
        case ($urandom_range(5))
            0: return 32'd16384;
            1: return -32'sd16384;
            2: return $urandom();                       // upper bits masked off
            default: return 32'(signed'($urandom_range(32768)) - 16384);
        endcase
    endfunction

    function automatic logic [31:0] rand_pos();
        case ($urandom_range(3))
            0: return $urandom();
            default: return 32'(signed'($urandom_range(1 << 23)) - (1 << 22));
        endcase
    endfunction

    // directed rows; the first group runs on reset registers
    t_vrow rows[] = '{
        '{0, 0, 0, 0, 1, 500, 260, 1},              // zero depth raised to minimum
        '{1, 10, 0, 1, 1, 545, 260, 0},             // depth exactly at minimum
        '{1023, 10, 0, 0, 1, 32767, 260, 0},        // x saturates high
        '{-1024, 10, 0, 0, 1, -32768, 260, 0},      // x saturates low
        '{0, 10, 1023, 0, 1, 500, -32768, 0},       // y saturates low
        '{0, 10, -1024, 1, 1, 500, 32767, 0},       // y saturates high
        '{0, 1023, 0, 0, 1, 500, 260, 0},
        '{0, -1024, 0, 1, 1, 500, 260, 1},          // negative depth
        '{-1024, -1024, -1024, 1, 1, -32768, 32767, 1},
        '{1023, 1023, 1023, 0, 0, 0, 0, 0},
        '{-1, 37, 5, 0, 0, 0, 0, 0}
    };
    t_vrow rot_rows[] = '{
        '{1023, 1023, 1023, 1, 0, 0, 0, 0},
        '{-1024, -1024, -1024, 0, 0, 0, 0, 0},
        '{1023, -1024, 0, 0, 0, 0, 0, 0},
        '{-1024, 1023, 511, 1, 0, 0, 0, 0},
        '{300, 200, -100, 0, 0, 0, 0, 0},
        '{-7, 9, 0, 1, 0, 0, 0, 0}
    };

    initial begin
        int nitems, phase;
        i_rst_n = 1'b0;
        i_cfg_we = 1'b0; i_cfg_idx = '0; i_cfg_wdata = '0;
        s_tvalid = 1'b0; s_tdata = '0; s_tlast = 1'b0;
        m_tready = 1'b1;
        gap_pct = 0; stall_pct = 0; hold = 0; hold_req = 0;
        typed_pending = 0; beats_in = 0; beats_out = 0; mism = 0;
        idle_cycles = 0; clamped_seen = 0;
        rot_on = 0; off_x = 0; off_y = 0; vw_cos = 16384; vw_sin = 0;
        hgt = 0; pt_cos = 16384; pt_sin = 0;
        repeat (9) @(negedge i_clk);
        i_rst_n = 1'b1;

        foreach (rows[k]) begin
            if (rows[k].typed) begin
                typed_res = '{16'(rows[k].sx), 16'(rows[k].sy), rows[k].clamped, rows[k].lst};
                typed_pending = 1;
            end
            send_vertex(11'(rows[k].vx), 11'(rows[k].vy), 11'(rows[k].vz), rows[k].lst);
        end
        drain();

        // part rotation by a quarter turn, view trig at out-of-range extremes
        write_reg(vpp_pkg::CFG_ROTATE_PART, 32'hffff_fffe | 32'd1);
        write_reg(vpp_pkg::CFG_PART_COS, 32'h1234_0000);
        write_reg(vpp_pkg::CFG_PART_SIN, 32'd16384);
        write_reg(vpp_pkg::CFG_VIEW_COS, 32'habcd_7fff);
        write_reg(vpp_pkg::CFG_VIEW_SIN, 32'h0000_8000);
        write_reg(vpp_pkg::CFG_OFFSET_X, 32'h8000_0000);
        write_reg(vpp_pkg::CFG_OFFSET_Y, 32'h8000_0000);
        write_reg(vpp_pkg::CFG_HEIGHT_OFFSET, 32'h7fff_ffff);
        foreach (rot_rows[k])
            send_vertex(11'(rot_rows[k].vx), 11'(rot_rows[k].vy), 11'(rot_rows[k].vz),
                        rot_rows[k].lst);
        drain();

        // random part: seven settings, idling mode cycles through the four kinds
        for (phase = 0; phase < 7; phase++) begin
            write_reg(vpp_pkg::CFG_ROTATE_PART, $urandom());
            if (phase == 1) begin          // offsets, height, part trig at maxima; view trig at 1.0
                write_reg(vpp_pkg::CFG_OFFSET_X, 32'h7fff_ffff);
                write_reg(vpp_pkg::CFG_OFFSET_Y, 32'h7fff_ffff);
                write_reg(vpp_pkg::CFG_VIEW_COS, 32'd16384);
                write_reg(vpp_pkg::CFG_VIEW_SIN, 32'd16384);
                write_reg(vpp_pkg::CFG_HEIGHT_OFFSET, 32'h7fff_ffff);
                write_reg(vpp_pkg::CFG_PART_COS, 32'h0000_7fff);
                write_reg(vpp_pkg::CFG_PART_SIN, 32'h0000_7fff);
            end else if (phase == 4) begin // offsets, height, part trig at minima; view trig at -1.0
                write_reg(vpp_pkg::CFG_OFFSET_X, 32'h8000_0000);
                write_reg(vpp_pkg::CFG_OFFSET_Y, 32'h8000_0000);
                write_reg(vpp_pkg::CFG_VIEW_COS, -32'sd16384);
                write_reg(vpp_pkg::CFG_VIEW_SIN, -32'sd16384);
                write_reg(vpp_pkg::CFG_HEIGHT_OFFSET, 32'h8000_0000);
                write_reg(vpp_pkg::CFG_PART_COS, 32'h0000_8000);
                write_reg(vpp_pkg::CFG_PART_SIN, 32'h0000_8000);
            end else begin
                write_reg(vpp_pkg::CFG_OFFSET_X, rand_pos());
                write_reg(vpp_pkg::CFG_OFFSET_Y, rand_pos());
                write_reg(vpp_pkg::CFG_VIEW_COS, rand_trig());
                write_reg(vpp_pkg::CFG_VIEW_SIN, rand_trig());
                write_reg(vpp_pkg::CFG_HEIGHT_OFFSET, rand_pos());
                write_reg(vpp_pkg::CFG_PART_COS, rand_trig());
                write_reg(vpp_pkg::CFG_PART_SIN, rand_trig());
            end
            case (phase % 4)
                0: begin gap_pct = 0;  stall_pct = 0;  end
                1: begin gap_pct = 48; stall_pct = 0;  end
                2: begin gap_pct = 0;  stall_pct = 48; end
                default: begin gap_pct = 19; stall_pct = 19; end
            endcase
            for (nitems = 0; nitems < 150; nitems++) begin
                if (phase == 0 && nitems == 40) hold_req = 1;   // fill the pipe
                if (phase == 3 && nitems == 75) drain();        // empty it mid-phase
                send_vertex(11'($urandom()), 11'($urandom()), 11'($urandom()),
                            1'($urandom()));
            end
            drain();
        end

        $display("%0d vertices in, %0d positions out, %0d with depth raised",
                 beats_in, beats_out, clamped_seen);
        $display("nine register settings incl. extremes; four idling modes and a long sink hold");
        if (mism == 0 && screen_q.size() == 0)
            $display("No mismatches found");
        else
            $display("Mismatches found");
        $finish;
    end
endmodule
`default_nettype wire

FILE: files.f
sv/vpp_pkg.sv
sv/vpp_div.sv
sv/vertex_perspective_projector.sv
tb/vertex_perspective_projector_tb.sv
